// File: src/i2c_master_transaction_engine_core_macros.svh
// assertion macros for the i2c master transaction engine
// no dependencies
`ifndef I2C_MASTER_TRANSACTION_ENGINE_CORE_MACROS_SVH
`define I2C_MASTER_TRANSACTION_ENGINE_CORE_MACROS_SVH
// implication checked every clock, off in reset
`define IMTE_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("imte check");
// next-cycle implication
`define IMTE_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("imte check");
`endif

// File: src/imte_pkg.sv
// package for the i2c master transaction engine
// types and constants, no dependencies
`timescale 1ns / 1ps
package imte_pkg;
  localparam logic [2:0] CMD_WRITE_REG = 3'd1;
  localparam logic [2:0] CMD_WRITE     = 3'd2;
  localparam logic [2:0] CMD_READ_REG  = 3'd3;
  localparam logic [2:0] CMD_READ      = 3'd4;
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_START_FAIL = 2'd1;
  localparam logic [1:0] ST_ADDR_NACK  = 2'd2;
  localparam logic [15:0] DELAY_RESET  = 16'd200;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] device_address;
    logic [7:0] register_address;
    logic [7:0] byte_count;
    logic [7:0] write_data;
    logic       write_data_valid;
    logic       scl_in;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       write_request;
    logic [7:0] read_data;
    logic       read_valid;
    logic       read_last;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } out_t;
endpackage

// File: src/i2c_master_transaction_engine_core.sv
// Each accepted request is one timing tick of the bus engine and yields exactly one result.
// Requests are taken one per clock while the result queue has room, so throughput is
// one tick per cycle as long as results are popped; a request waits in the request queue
// and its result goes to the result queue on its tick. Bus timing counts ticks, not clocks.
// depends on imte_pkg, imte_fifo, imte_engine
`timescale 1ns / 1ps
module i2c_master_transaction_engine_core #(
  parameter int QDEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  imte_pkg::in_t  in_item,
  output logic           empty,
  input  logic           pop,
  output imte_pkg::out_t out_item,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [15:0]    cfg_data
);
  logic [15:0] delay_ticks;
  logic        q_empty, q_full, q_rd, o_full, tick;
  imte_pkg::in_t q_item;
  imte_pkg::out_t res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) delay_ticks <= imte_pkg::DELAY_RESET;
    else if (cfg_valid) delay_ticks <= cfg_data;
  end

  imte_fifo #(.DEPTH(QDEPTH), .W($bits(imte_pkg::in_t))) u_inq (
    .clk, .rst, .wr(push), .wdata(in_item), .full(q_full),
    .rd(q_rd), .rdata(q_item), .empty(q_empty)
  );
  assign full = q_full;
  assign tick = !q_empty && !o_full;
  assign q_rd = tick;

  imte_engine u_eng (
    .clk, .rst, .delay_ticks, .tick, .in_req(q_item), .res
  );

  imte_fifo #(.DEPTH(QDEPTH), .W($bits(imte_pkg::out_t))) u_outq (
    .clk, .rst, .wr(tick), .wdata(res), .full(o_full),
    .rd(pop), .rdata(out_item), .empty(empty)
  );
endmodule

// File: src/imte_fifo.sv
// small request queue with registered storage
// no dependencies
`timescale 1ns / 1ps
module imte_fifo #(
  parameter int DEPTH = 2,
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  logic [W-1:0] mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;
  logic do_wr, do_rd;

  assign full  = (cnt == (AW+1)'(DEPTH));
  assign empty = (cnt == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wp] <= wdata;
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (do_wr) wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (do_rd) rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end
endmodule

// File: src/imte_engine.sv
// bus sequencer: takes one tick request a cycle while tick is high, produces one result
// depends on imte_pkg and the macros header
`timescale 1ns / 1ps
`include "i2c_master_transaction_engine_core_macros.svh"
module imte_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic [15:0]    delay_ticks,
  input  logic           tick,
  input  imte_pkg::in_t  in_req,
  output imte_pkg::out_t res
);
  typedef enum logic [4:0] {
    IDLE, S1, S2, S3, B1, B2, B3, B4, W1, W2, W3, W4, WDATA,
    R1, R2, R3, K1, K2, K3, K4, KX, P1, P2, P3, P4, DONE
  } phase_t;
  typedef enum logic [2:0] {SG_ADDR, SG_REG, SG_RSTART, SG_RADDR, SG_DATA} stage_t;

  phase_t phase, phase_next;
  stage_t stage, stage_next;
  logic [2:0] mode, mode_next;
  logic [15:0] dcnt, dcnt_next;
  logic [3:0] bitc, bitc_next;
  logic [7:0] sh, sh_next, left, left_next, dev, dev_next, rega, rega_next;
  logic scl, scl_next, sda, sda_next;
  logic [1:0] rst_st, rst_st_next;
  imte_pkg::out_t o;
  logic [15:0] dl;

  assign dl = (delay_ticks == 16'd0) ? 16'd0 : delay_ticks - 16'd1;

  always_comb begin
    phase_next = phase; stage_next = stage; mode_next = mode; dcnt_next = dcnt;
    bitc_next = bitc; sh_next = sh; left_next = left; dev_next = dev;
    rega_next = rega; scl_next = scl; sda_next = sda; rst_st_next = rst_st;
    o = '0;
    if (dcnt != 16'd0) begin
      dcnt_next = dcnt - 16'd1;
    end else begin
      dcnt_next = 16'd0;
      case (phase)
        IDLE: begin
          if (in_req.command inside {[3'd1:3'd4]}) begin
            mode_next = in_req.command; dev_next = in_req.device_address;
            rega_next = in_req.register_address; left_next = in_req.byte_count;
            stage_next = SG_ADDR; rst_st_next = imte_pkg::ST_OK; phase_next = S1;
          end
        end
        S1: begin sda_next = 1'b1; scl_next = 1'b1; phase_next = S2; dcnt_next = dl; end
        S2: begin
          if (!in_req.scl_in) begin
            scl_next = 1'b1; sda_next = 1'b1; rst_st_next = imte_pkg::ST_START_FAIL;
            phase_next = DONE;
          end else begin
            sda_next = 1'b0; phase_next = S3; dcnt_next = dl;
          end
        end
        S3: begin
          if (in_req.sda_in) begin
            scl_next = 1'b1; sda_next = 1'b1; rst_st_next = imte_pkg::ST_START_FAIL;
            phase_next = DONE;
          end else begin
            scl_next = 1'b0;
            if (stage == SG_RSTART) begin
              sh_next = dev | 8'h01; stage_next = SG_RADDR;
            end else begin
              sh_next = (mode == imte_pkg::CMD_READ) ? (dev | 8'h01) : (dev & 8'hFE);
              stage_next = SG_ADDR;
            end
            bitc_next = 4'd8; phase_next = B1; dcnt_next = dl;
          end
        end
        B1: begin scl_next = 1'b0; phase_next = B2; dcnt_next = dl; end
        B2: begin
          sda_next = sh[7]; sh_next = {sh[6:0], 1'b0}; phase_next = B3; dcnt_next = dl;
        end
        B3: begin scl_next = 1'b1; phase_next = B4; dcnt_next = dl; end
        B4: begin
          if (bitc != 4'd0) bitc_next = bitc - 4'd1;
          phase_next = (bitc > 4'd1) ? B1 : W1; dcnt_next = dl;
        end
        W1: begin scl_next = 1'b0; phase_next = W2; dcnt_next = dl; end
        W2: begin sda_next = 1'b1; phase_next = W3; dcnt_next = dl; end
        W3: begin scl_next = 1'b1; phase_next = W4; dcnt_next = dl; end
        W4: begin
          scl_next = 1'b0;
          if ((stage == SG_ADDR || stage == SG_RADDR) && in_req.sda_in) begin
            rst_st_next = imte_pkg::ST_ADDR_NACK; phase_next = P1;
          end else if ((stage == SG_ADDR || stage == SG_RADDR) &&
                       (stage == SG_RADDR || mode == imte_pkg::CMD_READ)) begin
            stage_next = SG_DATA;
            if (left == 8'd0) phase_next = P1;
            else begin bitc_next = 4'd8; sh_next = 8'd0; phase_next = R1; end
          end else if (stage == SG_ADDR && mode != imte_pkg::CMD_WRITE) begin
            sh_next = rega; stage_next = SG_REG; bitc_next = 4'd8; phase_next = B1;
          end else if (stage == SG_REG && mode == imte_pkg::CMD_READ_REG) begin
            stage_next = SG_RSTART; phase_next = S1;
          end else begin
            stage_next = SG_DATA;
            if (left == 8'd0) phase_next = P1;
            else begin left_next = left - 8'd1; phase_next = WDATA; end
          end
        end
        WDATA: begin
          scl_next = 1'b0; o.write_request = 1'b1;
          if (in_req.write_data_valid) begin
            sh_next = in_req.write_data; bitc_next = 4'd8; phase_next = B1;
          end
        end
        R1: begin scl_next = 1'b0; sda_next = 1'b1; phase_next = R2; dcnt_next = dl; end
        R2: begin scl_next = 1'b1; phase_next = R3; dcnt_next = dl; end
        R3: begin
          sh_next = {sh[6:0], in_req.sda_in};
          if (bitc > 4'd1) begin
            bitc_next = bitc - 4'd1; phase_next = R1;
          end else begin
            bitc_next = 4'd0; scl_next = 1'b0;
            if (left != 8'd0) left_next = left - 8'd1;
            o.read_data = {sh[6:0], in_req.sda_in}; o.read_valid = 1'b1;
            o.read_last = (left <= 8'd1); phase_next = K1;
          end
        end
        K1: begin scl_next = 1'b0; phase_next = K2; dcnt_next = dl; end
        K2: begin sda_next = (left == 8'd0); phase_next = K3; dcnt_next = dl; end
        K3: begin scl_next = 1'b1; phase_next = K4; dcnt_next = dl; end
        K4: begin scl_next = 1'b0; phase_next = KX; dcnt_next = dl; end
        KX: begin
          stage_next = SG_DATA;
          if (left == 8'd0) phase_next = P1;
          else begin bitc_next = 4'd8; sh_next = 8'd0; phase_next = R1; end
        end
        P1: begin sda_next = 1'b0; phase_next = P2; dcnt_next = dl; end
        P2: begin scl_next = 1'b0; phase_next = P3; dcnt_next = dl; end
        P3: begin scl_next = 1'b1; phase_next = P4; dcnt_next = dl; end
        P4: begin sda_next = 1'b1; phase_next = DONE; dcnt_next = dl; end
        DONE: begin o.done_res = 1'b1; o.status = rst_st; phase_next = IDLE; end
        default: phase_next = IDLE;
      endcase
    end
    o.scl_release = scl_next;
    o.sda_release = sda_next;
    o.busy_res = (phase_next != IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= IDLE; stage <= SG_ADDR; mode <= '0; dcnt <= '0; bitc <= '0;
      sh <= '0; left <= '0; dev <= '0; rega <= '0; scl <= 1'b1; sda <= 1'b1;
      rst_st <= imte_pkg::ST_OK;
    end else if (tick) begin
      phase <= phase_next; stage <= stage_next; mode <= mode_next; dcnt <= dcnt_next;
      bitc <= bitc_next; sh <= sh_next; left <= left_next; dev <= dev_next;
      rega <= rega_next; scl <= scl_next; sda <= sda_next; rst_st <= rst_st_next;
    end
  end
  assign res = o;

  `IMTE_ASSERT_IMP(a_done_idle, clk, rst, tick && o.done_res, !o.busy_res)
  `IMTE_ASSERT_IMP(a_wreq_scl, clk, rst, tick && o.write_request, !o.scl_release)
  `IMTE_ASSERT_NXT(a_hold, clk, rst, !tick, $stable(phase) && $stable(dcnt))
endmodule
